// File: src/ssp_pkg.sv
// Package: payload types, codes and constants of the segment stream parser.
package ssp_pkg;

	localparam int NUMBER_BITS_DEF = 63;
	localparam int SEG_BITS        = 63;
	localparam int CFG_DATA_BITS   = 64;
	localparam int CFG_ADDR_BITS   = 4;

	// Register select, taken from paddr[3] (registers sit 8 bytes apart)
	localparam logic REG_LIMIT_ENABLE = 1'b0;
	localparam logic REG_SIZE_LIMIT   = 1'b1;

	// Result kinds
	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_END     = 2'd2;
	localparam logic [1:0] KIND_ERROR   = 2'd3;

	// Error codes
	localparam logic [2:0] ERR_TOO_LARGE  = 3'd0;
	localparam logic [2:0] ERR_BAD_DIGIT  = 3'd1;
	localparam logic [2:0] ERR_BAD_NL     = 3'd2;
	localparam logic [2:0] ERR_OVERLAP    = 3'd3;
	localparam logic [2:0] ERR_OVER_LIMIT = 3'd4;
	localparam logic [2:0] ERR_TRUNCATED  = 3'd5;

	// Characters
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_NL    = 8'h0A;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_stream;
	} item_t;

	typedef struct packed {
		logic [1:0]          result_kind;
		logic [SEG_BITS-1:0] seg_offset;
		logic [SEG_BITS-1:0] seg_length;
		logic [7:0]          data_byte;
		logic                last_in_segment;
		logic [2:0]          error_code;
	} result_t;

endpackage

// File: src/sparse_segment_stream_parser.sv
// Top level: segment stream parser with APB configuration and one result register.
//
// Usage
//   Bytes of a segment stream come in on the item channel (item_valid/item_ready,
//   payload item). Each segment is an ASCII header "offset length\n" followed by
//   length raw bytes. One request carries one byte or an end-of-stream mark.
//   Results leave on the result channel (result_valid/result_ready): a header
//   report, a passed-through payload byte, a clean end, or an error.
//   A result is registered: it appears in the cycle after the request that causes it.
//   Throughput: one request per cycle while the result side does not stall; the
//   header parse, the multiply-by-ten digit accumulate and the order/limit checks
//   all settle combinationally between the state registers and the result register.
//   Stall: the result register holds while result_ready is low; item_ready
//   stays high as long as the result register is empty or being drained.
//   Errors are sticky: after one error report every later request is taken
//   and dropped until reset.
//   Reset (arst_n low) clears the parse state, the previous segment end and
//   both configuration registers (size limit off). Configuration is written
//   over APB at byte 0 (limit_enable) and byte 8 (size_limit).
module sparse_segment_stream_parser
	import ssp_pkg::*;
#(
	parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration port
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [CFG_ADDR_BITS-1:0] paddr,
	input  logic [CFG_DATA_BITS-1:0] pwdata,
	output logic [CFG_DATA_BITS-1:0] prdata,
	output logic                     pready,
	// byte stream in
	input  logic                     item_valid,
	output logic                     item_ready,
	input  item_t                    item,
	// results out
	output logic                     result_valid,
	input  logic                     result_ready,
	output result_t                  result
);

	localparam int NB = NUMBER_BITS;
	localparam logic [NB-1:0] NUM_MAX = {NB{1'b1}};

	// parse phases
	localparam logic [2:0] PH_OFFSET  = 3'd0;
	localparam logic [2:0] PH_LENGTH  = 3'd1;
	localparam logic [2:0] PH_NEWLINE = 3'd2;
	localparam logic [2:0] PH_PAYLOAD = 3'd3;
	localparam logic [2:0] PH_ERROR   = 3'd4;

	// configuration registers
	logic                limit_enable_q;
	logic [SEG_BITS-1:0] size_limit_q;

	// parse state
	logic [2:0]    phase_q, phase_nxt;
	logic [NB-1:0] offset_acc_q, offset_acc_nxt;
	logic [NB-1:0] length_rem_q, length_rem_nxt;
	logic          offset_begun_q, offset_begun_nxt;
	logic          length_begun_q, length_begun_nxt;
	logic [NB-1:0] last_end_q, last_end_nxt;

	// result register
	logic    res_valid_q;
	result_t res_q;
	result_t res_nxt;
	logic    emit;

	logic          accept;
	logic          cfg_write;
	logic          is_digit, is_space, is_nl;
	logic [3:0]    digit;
	logic [NB-1:0] acc_sel;
	logic [NB+3:0] acc_times_ten;
	logic          acc_overflow;
	logic [NB:0]   end_sum;
	logic          hdr_overlap, hdr_over_limit;

	//------------------------------------------------------------------
	// Configuration port: zero wait states, register picked by paddr[3]
	//------------------------------------------------------------------
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_enable_q <= 1'b0;
			size_limit_q   <= '0;
		end else if (cfg_write) begin
			case (paddr[3])
				REG_LIMIT_ENABLE: limit_enable_q <= pwdata[0];
				REG_SIZE_LIMIT:   size_limit_q   <= pwdata[SEG_BITS-1:0];
				default:          ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3])
			REG_LIMIT_ENABLE: prdata = CFG_DATA_BITS'(limit_enable_q);
			REG_SIZE_LIMIT:   prdata = CFG_DATA_BITS'(size_limit_q);
			default:          prdata = '0;
		endcase
	end

	//------------------------------------------------------------------
	// Handshake: take a request whenever the result slot is free or
	// drains this cycle.
	//------------------------------------------------------------------
	assign item_ready   = !res_valid_q || result_ready;
	assign accept       = item_valid && item_ready;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	//------------------------------------------------------------------
	// Character classes and the shared digit accumulator.
	// acc*10 + d is formed as (acc<<3) + (acc<<1) + d; any bit at or above
	// NB means the number no longer fits.
	//------------------------------------------------------------------
	always_comb begin
		is_digit = item.in_byte inside {[CHAR_ZERO:CHAR_NINE]};
		is_space = (item.in_byte == CHAR_SPACE);
		is_nl    = (item.in_byte == CHAR_NL);
	end

	assign digit         = 4'(item.in_byte - CHAR_ZERO);
	assign acc_sel       = (phase_q == PH_OFFSET) ? offset_acc_q : length_rem_q;
	assign acc_times_ten = ({acc_sel, 3'b000} + (NB+4)'({acc_sel, 1'b0}))
	                       + (NB+4)'(digit);
	assign acc_overflow  = |acc_times_ten[NB+3:NB];

	//------------------------------------------------------------------
	// Header checks. offset + len > size_limit covers both limit tests:
	// a length above the limit always pushes the sum above it as well.
	//------------------------------------------------------------------
	assign end_sum        = (NB+1)'(offset_acc_q) + (NB+1)'(length_rem_q);
	assign hdr_overlap    = (offset_acc_q < last_end_q);
	assign hdr_over_limit = limit_enable_q && (64'(end_sum) > 64'(size_limit_q));

	//------------------------------------------------------------------
	// Next state and result for the request in hand
	//------------------------------------------------------------------
	always_comb begin
		phase_nxt        = phase_q;
		offset_acc_nxt   = offset_acc_q;
		length_rem_nxt   = length_rem_q;
		offset_begun_nxt = offset_begun_q;
		length_begun_nxt = length_begun_q;
		last_end_nxt     = last_end_q;
		emit             = 1'b0;
		res_nxt          = '0;

		if (phase_q == PH_OFFSET || phase_q == PH_LENGTH || phase_q == PH_NEWLINE
		    || phase_q == PH_PAYLOAD) begin
			if (item.end_of_stream) begin
				emit = 1'b1;
				if (offset_begun_q || phase_q == PH_PAYLOAD) begin
					phase_nxt          = PH_ERROR;
					res_nxt.result_kind = KIND_ERROR;
					res_nxt.error_code  = ERR_TRUNCATED;
				end else begin
					res_nxt.result_kind = KIND_END;
				end
			end else begin
				case (phase_q)
					PH_OFFSET, PH_LENGTH: begin
						if (is_digit) begin
							if (acc_overflow) begin
								emit                = 1'b1;
								phase_nxt           = PH_ERROR;
								res_nxt.result_kind = KIND_ERROR;
								res_nxt.error_code  = ERR_TOO_LARGE;
							end else if (phase_q == PH_OFFSET) begin
								offset_acc_nxt   = acc_times_ten[NB-1:0];
								offset_begun_nxt = 1'b1;
							end else begin
								length_rem_nxt   = acc_times_ten[NB-1:0];
								length_begun_nxt = 1'b1;
							end
						end else if (phase_q == PH_OFFSET && (is_space || is_nl)) begin
							if (offset_begun_q) begin
								phase_nxt = PH_LENGTH;
							end
						end else if (phase_q == PH_LENGTH && is_space) begin
							if (length_begun_q) begin
								phase_nxt = PH_NEWLINE;
							end
						end else if (phase_q == PH_LENGTH && is_nl) begin
							if (length_begun_q) begin
								emit = 1'b1;
							end
						end else begin
							emit                = 1'b1;
							phase_nxt           = PH_ERROR;
							res_nxt.result_kind = KIND_ERROR;
							res_nxt.error_code  = ERR_BAD_DIGIT;
						end
					end
					PH_NEWLINE: begin
						if (is_nl) begin
							emit = 1'b1;
						end else if (!is_space) begin
							emit                = 1'b1;
							phase_nxt           = PH_ERROR;
							res_nxt.result_kind = KIND_ERROR;
							res_nxt.error_code  = ERR_BAD_NL;
						end
					end
					PH_PAYLOAD: begin
						emit                    = 1'b1;
						length_rem_nxt          = length_rem_q - NB'(1);
						res_nxt.result_kind     = KIND_PAYLOAD;
						res_nxt.data_byte       = item.in_byte;
						res_nxt.last_in_segment = (length_rem_q == NB'(1));
						if (length_rem_q == NB'(1)) begin
							phase_nxt        = PH_OFFSET;
							offset_acc_nxt   = '0;
							offset_begun_nxt = 1'b0;
							length_begun_nxt = 1'b0;
						end
					end
					default: ;
				endcase

				// header closed by a newline in the length or newline phase
				if (emit && res_nxt.result_kind == KIND_HEADER
				    && phase_nxt != PH_ERROR) begin
					if (hdr_overlap) begin
						phase_nxt           = PH_ERROR;
						res_nxt.result_kind = KIND_ERROR;
						res_nxt.error_code  = ERR_OVERLAP;
					end else if (hdr_over_limit) begin
						phase_nxt           = PH_ERROR;
						res_nxt.result_kind = KIND_ERROR;
						res_nxt.error_code  = ERR_OVER_LIMIT;
					end else begin
						last_end_nxt       = end_sum[NB] ? NUM_MAX : end_sum[NB-1:0];
						res_nxt.seg_offset = SEG_BITS'(offset_acc_q);
						res_nxt.seg_length = SEG_BITS'(length_rem_q);
						if (length_rem_q == '0) begin
							// empty segment: report it as its own last byte
							res_nxt.last_in_segment = 1'b1;
							phase_nxt        = PH_OFFSET;
							offset_acc_nxt   = '0;
							offset_begun_nxt = 1'b0;
							length_begun_nxt = 1'b0;
						end else begin
							phase_nxt = PH_PAYLOAD;
						end
					end
				end
			end
		end
	end

	//------------------------------------------------------------------
	// State registers: advance on every taken request
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_OFFSET;
			offset_acc_q   <= '0;
			length_rem_q   <= '0;
			offset_begun_q <= 1'b0;
			length_begun_q <= 1'b0;
			last_end_q     <= '0;
		end else if (accept) begin
			phase_q        <= phase_nxt;
			offset_acc_q   <= offset_acc_nxt;
			length_rem_q   <= length_rem_nxt;
			offset_begun_q <= offset_begun_nxt;
			length_begun_q <= length_begun_nxt;
			last_end_q     <= last_end_nxt;
		end
	end

	// Result register: load on a request that reports, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept && emit) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			res_q <= res_nxt;
		end
	end

endmodule

// File: verif/ssp_check_pkg.sv
// Testbench package: expected-result model and result checker of the segment stream parser.
`timescale 1ns / 1ps
package ssp_check_pkg;
	import ssp_pkg::*;

	localparam logic [63:0] NUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef enum logic [2:0] {
		AWAIT_OFFSET,
		AWAIT_LENGTH,
		AWAIT_NEWLINE,
		IN_PAYLOAD,
		STUCK
	} parse_phase_t;

	class parser_scoreboard;
		logic         limit_on;
		logic [62:0]  size_cap;
		parse_phase_t phase;
		logic [63:0]  offset_sum;
		logic [63:0]  length_left;
		logic [63:0]  last_end;
		bit           offset_seen;
		bit           length_seen;
		result_t      pending_results[$];
		int           error_count;

		function new();
			limit_on = 1'b0;
			size_cap = '0;
			last_end = '0;
			error_count = 0;
			start_segment();
		endfunction

		function void start_segment();
			phase = AWAIT_OFFSET;
			offset_sum = '0;
			length_left = '0;
			offset_seen = 1'b0;
			length_seen = 1'b0;
		endfunction

		function void set_register(logic sel, logic [63:0] value);
			if (sel == REG_LIMIT_ENABLE) limit_on = value[0];
			else size_cap = value[62:0];
		endfunction

		function bit digit_fits(logic [63:0] acc, logic [63:0] digit);
			return acc <= (NUM_MAX - digit) / 10;
		endfunction

		function result_t fault(logic [2:0] code);
			result_t r;
			r = '0;
			r.result_kind = KIND_ERROR;
			r.error_code = code;
			phase = STUCK;
			return r;
		endfunction

		// Header complete: order and limit checks, then report it.
		function result_t close_header();
			result_t r;
			logic [63:0] seg_end;
			r = '0;
			if (offset_sum < last_end) return fault(ERR_OVERLAP);
			if (limit_on && (length_left > 64'(size_cap)
					|| offset_sum > 64'(size_cap) - length_left))
				return fault(ERR_OVER_LIMIT);
			seg_end = offset_sum + length_left;
			last_end = (seg_end > NUM_MAX) ? NUM_MAX : seg_end;
			r.result_kind = KIND_HEADER;
			r.seg_offset = offset_sum[62:0];
			r.seg_length = length_left[62:0];
			if (length_left == 0) begin
				r.last_in_segment = 1'b1;
				start_segment();
			end else begin
				phase = IN_PAYLOAD;
			end
			return r;
		endfunction

		// Advance the parse by one accepted request and queue what it yields.
		function void take_request(item_t it);
			result_t r;
			logic [63:0] digit;
			bit is_digit;
			bit is_space;
			bit is_nl;
			bit made;
			r = '0;
			made = 1'b1;
			is_digit = it.in_byte >= CHAR_ZERO && it.in_byte <= CHAR_NINE;
			is_space = it.in_byte == CHAR_SPACE;
			is_nl = it.in_byte == CHAR_NL;
			digit = 64'(8'(it.in_byte - CHAR_ZERO));
			if (phase == STUCK) return;
			if (it.end_of_stream) begin
				if (offset_seen || phase == IN_PAYLOAD) r = fault(ERR_TRUNCATED);
				else r.result_kind = KIND_END;
			end else begin
				case (phase)
				AWAIT_OFFSET: begin
					if (is_digit) begin
						if (digit_fits(offset_sum, digit)) begin
							offset_sum = offset_sum * 64'd10 + digit;
							offset_seen = 1'b1;
							made = 1'b0;
						end else begin
							r = fault(ERR_TOO_LARGE);
						end
					end else if (is_space || is_nl) begin
						if (offset_seen) phase = AWAIT_LENGTH;
						made = 1'b0;
					end else begin
						r = fault(ERR_BAD_DIGIT);
					end
				end
				AWAIT_LENGTH: begin
					if (is_digit) begin
						if (digit_fits(length_left, digit)) begin
							length_left = length_left * 64'd10 + digit;
							length_seen = 1'b1;
							made = 1'b0;
						end else begin
							r = fault(ERR_TOO_LARGE);
						end
					end else if (is_space) begin
						if (length_seen) phase = AWAIT_NEWLINE;
						made = 1'b0;
					end else if (is_nl) begin
						if (length_seen) r = close_header();
						else made = 1'b0;
					end else begin
						r = fault(ERR_BAD_DIGIT);
					end
				end
				AWAIT_NEWLINE: begin
					if (is_space) made = 1'b0;
					else if (is_nl) r = close_header();
					else r = fault(ERR_BAD_NL);
				end
				default: begin
					length_left = length_left - 64'd1;
					r.result_kind = KIND_PAYLOAD;
					r.data_byte = it.in_byte;
					if (length_left == 0) begin
						r.last_in_segment = 1'b1;
						start_segment();
					end
				end
				endcase
			end
			if (made) pending_results.push_back(r);
		endfunction

		function void compare(string field, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				error_count++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				error_count++;
				$display("%0t: result mismatch, expected none, actual kind %0d", $time,
					got.result_kind);
				return;
			end
			want = pending_results.pop_front();
			compare("result_kind", 64'(want.result_kind), 64'(got.result_kind));
			compare("seg_offset", 64'(want.seg_offset), 64'(got.seg_offset));
			compare("seg_length", 64'(want.seg_length), 64'(got.seg_length));
			compare("data_byte", 64'(want.data_byte), 64'(got.data_byte));
			compare("last_in_segment", 64'(want.last_in_segment), 64'(got.last_in_segment));
			compare("error_code", 64'(want.error_code), 64'(got.error_code));
		endfunction
	endclass

endpackage

// File: verif/tb_sparse_segment_stream_parser.sv
// Testbench top: drives segment streams and config writes, checks every result against a model.
`timescale 1ns / 1ps
module tb_sparse_segment_stream_parser;
	import ssp_pkg::*;
	import ssp_check_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 6;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [CFG_ADDR_BITS-1:0] paddr;
	logic [CFG_DATA_BITS-1:0] pwdata;
	logic [CFG_DATA_BITS-1:0] prdata;
	logic                     pready;
	logic                     item_valid;
	logic                     item_ready;
	item_t                    item;
	logic                     result_valid;
	logic                     result_ready;
	result_t                  result;

	parser_scoreboard sb;
	bit idling_on = 1'b0;
	bit hold_request = 1'b0;
	int requests_sent = 0;
	int cycle_count = 0;

	sparse_segment_stream_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always #5 clk = ~clk;

	// Watchdog: a correct run ends far below this count.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Sample both handshakes at the rising edge. Check the result first: a request
	// taken at this same edge cannot have produced it, so it must not be matched.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) sb.check_result(result);
			if (item_valid && item_ready) sb.take_request(item);
		end
	end

	// Result side: random stall bursts while idling is on, and one long hold-off
	// on demand so that the result register fills and the input stalls.
	initial begin : result_sink
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				result_ready = 1'b0;
				hold_request = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (idling_on && $urandom_range(0, 7) == 0) begin
				result_ready = 1'b0;
				repeat ($urandom_range(1, 18) - 1) @(negedge clk);
			end else begin
				result_ready = 1'b1;
			end
		end
	end

	// Present one request at the falling edge and hold it until it is taken.
	// Valid stays high on return; a drain or an idle gap in the next call lowers it.
	task automatic send_request(input logic [7:0] b, input logic eos);
		if (idling_on && $urandom_range(0, 9) == 0) begin
			item_valid = 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		item.in_byte = b;
		item.end_of_stream = eos;
		item_valid = 1'b1;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_request(b, 1'b0);
	endtask

	task automatic send_end();
		send_request(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic send_text(input string text);
		for (int i = 0; i < text.len(); i++) send_byte(text[i]);
	endtask

	// Decimal digits of a number, most significant first, with optional leading zeros.
	task automatic send_number(input logic [63:0] value, input int zeros);
		logic [7:0] digits[$];
		logic [63:0] rest;
		rest = value;
		do begin
			digits.push_front(8'(CHAR_ZERO + rest % 10));
			rest = rest / 10;
		end while (rest != 0);
		repeat (zeros) digits.push_front(CHAR_ZERO);
		foreach (digits[i]) send_byte(digits[i]);
	endtask

	task automatic send_blanks(input int count);
		repeat (count) send_byte($urandom_range(0, 1) ? CHAR_SPACE : CHAR_NL);
	endtask

	// Full header; the noisy form adds skipped blanks, leading zeros and trailing spaces.
	task automatic send_header(input logic [63:0] off, input logic [63:0] len, input bit noisy);
		if (noisy) send_blanks(int'($urandom_range(0, 2)));
		send_number(off, noisy ? int'($urandom_range(0, 2)) : 0);
		send_byte($urandom_range(0, 1) ? CHAR_SPACE : CHAR_NL);
		if (noisy) send_blanks(int'($urandom_range(0, 2)));
		send_number(len, noisy ? int'($urandom_range(0, 2)) : 0);
		if (noisy && $urandom_range(0, 1)) repeat ($urandom_range(1, 3)) send_byte(CHAR_SPACE);
		send_byte(CHAR_NL);
	endtask

	// Any byte that is not a blank; digits only where asked.
	function automatic logic [7:0] stray_byte(input bit digits_ok);
		logic [7:0] b;
		do begin
			b = 8'($urandom_range(0, 255));
		end while (b == CHAR_SPACE || b == CHAR_NL ||
			(!digits_ok && b >= CHAR_ZERO && b <= CHAR_NINE));
		return b;
	endfunction

	// Drop valid and wait until every expected result is out and the block is quiet.
	task automatic wait_drained();
		item_valid = 1'b0;
		while (sb.pending_results.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// APB write, then read back over the same select (back-to-back transfers).
	task automatic write_register(input logic sel, input logic [63:0] value);
		logic [63:0] readback;
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {sel, 3'b000};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_register(sel, value);
		@(negedge clk);
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		readback = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		if (sel == REG_LIMIT_ENABLE ? readback[0] !== value[0]
				: readback[62:0] !== value[62:0]) begin
			sb.error_count++;
			$display("%0t: register %0d readback mismatch, expected %0h, actual %0h",
				$time, sel, value, readback);
		end
	endtask

	// Well-formed segments with random offsets, lengths, blanks and payload, and a
	// clean end mark now and then between segments. Capped phases keep every gap
	// small so that no segment reaches past the size limit.
	task automatic random_segments(input int quota, input bit capped);
		logic [63:0] off;
		logic [63:0] len;
		logic [63:0] gap;
		int stop_at;
		stop_at = requests_sent + quota;
		while (requests_sent < stop_at) begin
			idling_on = ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 7))
			0, 1: len = 64'd0;
			2: len = 64'($urandom_range(13, 40));
			default: len = 64'($urandom_range(1, 12));
			endcase
			case ($urandom_range(0, 7))
			0: gap = 64'd0;
			1: gap = capped ? 64'($urandom_range(0, 50)) : 64'($urandom) << $urandom_range(0, 8);
			default: gap = 64'($urandom_range(0, 50));
			endcase
			off = sb.last_end + gap;
			send_header(off, len, 1'($urandom_range(0, 1)));
			repeat (len) send_byte(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 9) == 0) send_end();
		end
	endtask

	initial begin : stimulus
		logic [63:0] cap;
		logic [63:0] lim;
		logic [2:0]  ending;
		sb = new();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_valid = 1'b0;
		item = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: limit off at its low extreme; clean end at reset, zero length,
		// skipped blanks, leading zeros, trailing spaces, payload bytes at both
		// extremes and one that looks like a separator.
		write_register(REG_LIMIT_ENABLE, 64'd0);
		write_register(REG_SIZE_LIMIT, 64'd0);
		idling_on = 1'b1;
		send_end();
		send_text("0 0\n");
		send_text(" \n007\n 2  \n");
		send_byte(8'h00);
		send_byte(8'hFF);
		send_end();
		send_text("9 1\n");
		send_byte(CHAR_NL);
		wait_drained();

		// Limit on at its top value, which no segment of this phase exceeds.
		write_register(REG_LIMIT_ENABLE, 64'd1);
		write_register(REG_SIZE_LIMIT, NUM_MAX);
		random_segments(450, 1'b0);
		wait_drained();

		// Tight limit above the current end; start with a long result hold-off
		// while requests keep coming. Finish with one segment ending exactly at
		// the limit and one zero-length header sitting on it.
		cap = sb.last_end + 64'd20000;
		write_register(REG_SIZE_LIMIT, cap);
		hold_request = 1'b1;
		random_segments(400, 1'b1);
		send_header(cap - 64'd3, 64'd3, 1'b0);
		repeat (3) send_byte(8'($urandom_range(0, 255)));
		send_header(cap, 64'd0, 1'b1);
		wait_drained();

		// Limit off with a random value left in the register.
		write_register(REG_LIMIT_ENABLE, 64'd0);
		write_register(REG_SIZE_LIMIT, {$urandom, $urandom} & NUM_MAX);
		random_segments(450, 1'b0);
		wait_drained();

		// Last stretch runs without idling. Push the segment end past the number
		// range so it saturates, then a header with the greatest offset.
		idling_on = 1'b0;
		send_header(NUM_MAX - 64'd2, 64'd5, 1'b0);
		repeat (5) send_byte(8'($urandom_range(0, 255)));
		send_header(NUM_MAX, 64'd0, 1'b0);
		send_end();

		// One error per run, since it sticks until reset; the seed picks which.
		ending = 3'($urandom_range(0, 5));
		case (ending)
		ERR_TOO_LARGE: begin
			if ($urandom_range(0, 1)) begin
				send_number(NUM_MAX, 0);
				send_byte(CHAR_SPACE);
			end
			if ($urandom_range(0, 1)) begin
				send_number(NUM_MAX, 0);
				send_byte(8'(CHAR_ZERO + $urandom_range(0, 9)));
			end else begin
				send_number(NUM_MAX / 10, 0);
				send_byte(8'(CHAR_ZERO + $urandom_range(8, 9)));
			end
		end
		ERR_BAD_DIGIT: begin
			if ($urandom_range(0, 1)) begin
				send_number(NUM_MAX, 0);
				send_byte(CHAR_SPACE);
			end
			if ($urandom_range(0, 1)) send_number(64'($urandom_range(0, 99)), 0);
			send_byte(stray_byte(1'b0));
		end
		ERR_BAD_NL: begin
			send_number(NUM_MAX, 0);
			send_byte(CHAR_SPACE);
			send_number(64'($urandom_range(0, 99)), 0);
			repeat ($urandom_range(1, 3)) send_byte(CHAR_SPACE);
			send_byte(stray_byte(1'b1));
		end
		ERR_OVERLAP: begin
			send_header(NUM_MAX - 64'd1 - 64'($urandom_range(0, 1000)),
				64'($urandom_range(0, 9)), 1'($urandom_range(0, 1)));
		end
		ERR_OVER_LIMIT: begin
			wait_drained();
			write_register(REG_LIMIT_ENABLE, 64'd1);
			if ($urandom_range(0, 1)) begin
				// Offset side of the check; a zero length sits exactly on the limit.
				write_register(REG_SIZE_LIMIT, NUM_MAX);
				send_header(NUM_MAX, 64'd0, 1'b1);
				send_header(NUM_MAX, 64'($urandom_range(1, 9)), 1'b1);
			end else begin
				// Length side of the check.
				lim = 64'($urandom_range(0, 1000));
				write_register(REG_SIZE_LIMIT, lim);
				send_header(NUM_MAX, lim + 64'($urandom_range(1, 9)), 1'b1);
			end
		end
		default: begin
			case ($urandom_range(0, 3))
			0: send_number(64'($urandom_range(0, 999)), 0);
			1: begin
				send_number(NUM_MAX, 0);
				send_byte(CHAR_SPACE);
			end
			2: begin
				send_number(NUM_MAX, 0);
				send_byte(CHAR_SPACE);
				send_number(64'($urandom_range(0, 99)), 0);
				send_byte(CHAR_SPACE);
			end
			default: begin
				// Greatest length: the payload can never be complete.
				send_header(NUM_MAX, NUM_MAX, 1'b0);
				repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
			end
			endcase
			send_end();
		end
		endcase

		// Everything after the error is dropped, end marks included.
		repeat (20) send_request(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
		wait_drained();

		if (sb.error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// File: sparse_segment_stream_parser.f
src/ssp_pkg.sv
src/sparse_segment_stream_parser.sv
verif/ssp_check_pkg.sv
verif/tb_sparse_segment_stream_parser.sv
